// ----- rtl/utf8e_pkg.sv -----
// Shared constants and types for the UTF-8 encoder with output budget.
// Used by utf8_encoder_with_budget_top; depends on nothing else.
package utf8e_pkg;

	localparam int unsigned COUNT_BITS_DEFAULT = 16;
	localparam int unsigned CP_W               = 32;
	localparam int unsigned BUDGET_W           = 16;
	localparam int unsigned TOTAL_W            = 16;

	localparam logic [CP_W-1:0] LIMIT_4B = 32'h001f_ffff;
	localparam logic [CP_W-1:0] LIMIT_3B = 32'h0000_ffff;
	localparam logic [CP_W-1:0] LIMIT_2B = 32'h0000_07ff;
	localparam logic [CP_W-1:0] LIMIT_1B = 32'h0000_007f;

	localparam logic [7:0] LEAD_4B = 8'hf0;
	localparam logic [7:0] LEAD_3B = 8'he0;
	localparam logic [7:0] LEAD_2B = 8'hc0;
	localparam logic [7:0] CONT_B  = 8'h80;

	typedef enum logic [2:0] {
		ST_ENCODED = 3'd0,
		ST_NO_ROOM = 3'd1,
		ST_ILLEGAL = 3'd2,
		ST_TERM    = 3'd3,
		ST_IGNORED = 3'd4
	} status_t;

endpackage

// ----- rtl/utf8_encoder_with_budget_top.sv -----
// UTF-8 encoder with output byte budget: input register, decode, byte buffer.
// An accepted code point is held in the input register, then decoded and
// loaded into the byte buffer, which feeds the one-byte result port; a new
// item is taken while the last byte of the previous waits.
// Reset (arst_n, asynchronous): channels empty, budget and count zero, stopped.
// Depends on utf8e_pkg.
module utf8_encoder_with_budget_top #(
	parameter int unsigned COUNT_BITS = utf8e_pkg::COUNT_BITS_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [utf8e_pkg::BUDGET_W-1:0] cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [utf8e_pkg::CP_W-1:0]     code_point,
	input  logic                           first_item,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           byte_valid,
	output logic [7:0]                     out_byte,
	output logic                           last,
	output logic [2:0]                     status,
	output logic [utf8e_pkg::TOTAL_W-1:0]  total_count
);

	// Configuration and conversion state
	logic [utf8e_pkg::BUDGET_W-1:0] budget_cfg_q;
	logic [utf8e_pkg::BUDGET_W-1:0] remaining_q;
	logic [COUNT_BITS-1:0]          count_q;
	logic                           stopped_q;

	// Input stage
	logic                       valid_s1;
	logic [utf8e_pkg::CP_W-1:0] cp_s1;
	logic                       first_s1;

	// Byte buffer stage
	logic                  valid_s2;
	logic [3:0][7:0]       bytes_s2;
	logic [1:0]            nlast_s2;
	logic [1:0]            idx_s2;
	logic                  bvalid_s2;
	utf8e_pkg::status_t    status_s2;
	logic [COUNT_BITS-1:0] base_s2;

	logic load;
	logic out_xfer;
	logic last_s2;

	// Decode
	logic [utf8e_pkg::BUDGET_W-1:0] rem_eff;
	logic [COUNT_BITS-1:0]          cnt_eff;
	logic                           stp_eff;
	logic [2:0]                     len;
	logic [3:0][7:0]                enc;
	logic                           illegal;
	utf8e_pkg::status_t             dec_status;
	logic [3:0][7:0]                dec_bytes;
	logic                           dec_bvalid;
	logic [1:0]                     dec_nlast;
	logic [utf8e_pkg::BUDGET_W-1:0] rem_next;
	logic [COUNT_BITS-1:0]          cnt_next;
	logic                           stp_next;

	logic [COUNT_BITS-1:0] cnt_out;

	assign last_s2  = (idx_s2 == nlast_s2);
	assign out_xfer = out_valid & out_ready;
	assign load     = valid_s1 & (~valid_s2 | (out_ready & last_s2));
	assign in_ready = ~valid_s1 | load;

	always_comb begin
		rem_eff = first_s1 ? budget_cfg_q : remaining_q;
		cnt_eff = first_s1 ? '0 : count_q;
		stp_eff = first_s1 ? 1'b0 : stopped_q;
		illegal = (cp_s1 & ~utf8e_pkg::LIMIT_4B) != '0;

		enc = '0;
		if ((cp_s1 & ~utf8e_pkg::LIMIT_3B) != '0) begin
			len    = 3'd4;
			enc[0] = utf8e_pkg::LEAD_4B | {5'b0, cp_s1[20:18]};
			enc[1] = utf8e_pkg::CONT_B | {2'b0, cp_s1[17:12]};
			enc[2] = utf8e_pkg::CONT_B | {2'b0, cp_s1[11:6]};
			enc[3] = utf8e_pkg::CONT_B | {2'b0, cp_s1[5:0]};
		end else if ((cp_s1 & ~utf8e_pkg::LIMIT_2B) != '0) begin
			len    = 3'd3;
			enc[0] = utf8e_pkg::LEAD_3B | {4'b0, cp_s1[15:12]};
			enc[1] = utf8e_pkg::CONT_B | {2'b0, cp_s1[11:6]};
			enc[2] = utf8e_pkg::CONT_B | {2'b0, cp_s1[5:0]};
		end else if ((cp_s1 & ~utf8e_pkg::LIMIT_1B) != '0) begin
			len    = 3'd2;
			enc[0] = utf8e_pkg::LEAD_2B | {3'b0, cp_s1[10:6]};
			enc[1] = utf8e_pkg::CONT_B | {2'b0, cp_s1[5:0]};
		end else begin
			len    = 3'd1;
			enc[0] = cp_s1[7:0];
		end

		dec_bytes  = '0;
		dec_bvalid = 1'b0;
		dec_nlast  = 2'd0;
		rem_next   = rem_eff;
		cnt_next   = cnt_eff;
		stp_next   = stp_eff;
		if (stp_eff) begin
			dec_status = utf8e_pkg::ST_IGNORED;
		end else if (rem_eff == '0) begin
			dec_status = utf8e_pkg::ST_NO_ROOM;
			stp_next   = 1'b1;
		end else if (illegal) begin
			dec_status = utf8e_pkg::ST_ILLEGAL;
			stp_next   = 1'b1;
		end else if (rem_eff < utf8e_pkg::BUDGET_W'(len)) begin
			dec_status = utf8e_pkg::ST_NO_ROOM;
			stp_next   = 1'b1;
		end else if (cp_s1 == '0) begin
			// terminator uses budget but is not counted
			dec_status = utf8e_pkg::ST_TERM;
			dec_bvalid = 1'b1;
			rem_next   = rem_eff - utf8e_pkg::BUDGET_W'(len);
			stp_next   = 1'b1;
		end else begin
			dec_status = utf8e_pkg::ST_ENCODED;
			dec_bvalid = 1'b1;
			dec_bytes  = enc;
			dec_nlast  = 2'(len - 3'd1);
			rem_next   = rem_eff - utf8e_pkg::BUDGET_W'(len);
			cnt_next   = cnt_eff + COUNT_BITS'(len);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_cfg_q <= '0;
			remaining_q  <= '0;
			count_q      <= '0;
			stopped_q    <= 1'b1;
		end else begin
			if (cfg_we) begin
				budget_cfg_q <= cfg_wdata;
			end
			if (load) begin
				remaining_q <= rem_next;
				count_q     <= cnt_next;
				stopped_q   <= stp_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cp_s1    <= code_point;
			first_s1 <= first_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_s2   <= '0;
		end else if (load) begin
			valid_s2 <= 1'b1;
			idx_s2   <= '0;
		end else if (out_xfer) begin
			// advance through the buffered bytes, drop after the last one
			if (last_s2) begin
				valid_s2 <= 1'b0;
			end else begin
				idx_s2 <= idx_s2 + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_s2  <= dec_bytes;
			nlast_s2  <= dec_nlast;
			bvalid_s2 <= dec_bvalid;
			status_s2 <= dec_status;
			base_s2   <= cnt_eff;
		end
	end

	always_comb begin
		cnt_out = base_s2;
		if (status_s2 == utf8e_pkg::ST_ENCODED) begin
			cnt_out = base_s2 + COUNT_BITS'(idx_s2) + COUNT_BITS'(1);
		end
	end

	assign out_valid   = valid_s2;
	assign byte_valid  = bvalid_s2;
	assign out_byte    = bytes_s2[idx_s2];
	assign last        = last_s2;
	assign status      = status_s2;
	assign total_count = utf8e_pkg::TOTAL_W'(cnt_out);

`ifndef NO_ASSERTIONS
	a_multi_only_encoded: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !last_s2 |-> status_s2 == utf8e_pkg::ST_ENCODED)
		else $error("multi-byte result without encoded status");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> idx_s2 <= nlast_s2)
		else $error("byte index beyond buffered length");

	a_stop_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		load && (dec_status == utf8e_pkg::ST_TERM || dec_status == utf8e_pkg::ST_ILLEGAL
			|| dec_status == utf8e_pkg::ST_NO_ROOM) |=> stopped_q)
		else $error("conversion not stopped after terminating result");

	a_no_load_mid_item: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !last_s2 |-> !load)
		else $error("buffer overwritten before its last byte");
`endif

endmodule

// ----- test/utf8_encoder_with_budget_top_tb.sv -----
// Self-checking testbench for utf8_encoder_with_budget_top: random bursts of code
// points against an in-bench UTF-8 encoder with a byte budget. Depends on utf8e_pkg.
`timescale 1ns / 100ps

module utf8_encoder_with_budget_top_tb;

	localparam int unsigned RUN_LIMIT = 2_000_000;

	typedef struct packed {
		logic [utf8e_pkg::CP_W-1:0] cp;
		logic                       first;
	} point_t;

	typedef struct packed {
		logic                          byte_valid;
		logic [7:0]                    value;
		logic                          last;
		utf8e_pkg::status_t            status;
		logic [utf8e_pkg::TOTAL_W-1:0] total;
	} enc_byte_t;

	logic                           clk         = 1'b0;
	logic                           arst_n      = 1'b0;
	logic                           cfg_we      = 1'b0;
	logic [utf8e_pkg::BUDGET_W-1:0] cfg_wdata   = '0;
	logic                           in_valid    = 1'b0;
	logic                           in_ready;
	logic [utf8e_pkg::CP_W-1:0]     code_point  = '0;
	logic                           first_item  = 1'b0;
	logic                           out_valid;
	logic                           out_ready   = 1'b0;
	logic                           byte_valid;
	logic [7:0]                     out_byte;
	logic                           last;
	logic [2:0]                     status;
	logic [utf8e_pkg::TOTAL_W-1:0]  total_count;

	point_t    pending_points [$];
	enc_byte_t due_bytes [$];

	// encoder state as the block should hold it
	logic [utf8e_pkg::BUDGET_W-1:0]           budget_reg = '0;
	logic [utf8e_pkg::BUDGET_W-1:0]           rem_budget = '0;
	logic [utf8e_pkg::COUNT_BITS_DEFAULT-1:0] enc_count  = '0;
	logic                                     halted     = 1'b1;

	int unsigned mismatches = 0;
	int unsigned cycles     = 0;
	int unsigned burst_left = 1;
	int unsigned gap_left   = 0;
	int unsigned stall_left = 0;
	int unsigned stall_mode = 0;
	int unsigned stall_tick = 0;

	utf8_encoder_with_budget_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.code_point (code_point),
		.first_item (first_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.byte_valid (byte_valid),
		.out_byte   (out_byte),
		.last       (last),
		.status     (status),
		.total_count(total_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void expect_byte(input logic bv, input logic [7:0] value,
		input logic is_last, input utf8e_pkg::status_t st);
		enc_byte_t r;
		r.byte_valid = bv;
		r.value      = value;
		r.last       = is_last;
		r.status     = st;
		r.total      = enc_count[utf8e_pkg::TOTAL_W-1:0];
		due_bytes.push_back(r);
	endfunction

	function automatic void encode_point(input logic [utf8e_pkg::CP_W-1:0] cp,
		input logic first);
		logic [7:0]  seq [4];
		int unsigned len;
		if (first) begin
			rem_budget = budget_reg;
			enc_count  = '0;
			halted     = 1'b0;
		end
		if (halted) begin
			expect_byte(1'b0, 8'h00, 1'b1, utf8e_pkg::ST_IGNORED);
			return;
		end
		// an empty budget wins over the illegal check
		if (rem_budget == 0) begin
			halted = 1'b1;
			expect_byte(1'b0, 8'h00, 1'b1, utf8e_pkg::ST_NO_ROOM);
			return;
		end
		if (cp > utf8e_pkg::LIMIT_4B) begin
			halted = 1'b1;
			expect_byte(1'b0, 8'h00, 1'b1, utf8e_pkg::ST_ILLEGAL);
			return;
		end
		if (cp > utf8e_pkg::LIMIT_3B) begin
			len    = 4;
			seq[0] = utf8e_pkg::LEAD_4B | {5'b0, cp[20:18]};
			seq[1] = utf8e_pkg::CONT_B | {2'b0, cp[17:12]};
			seq[2] = utf8e_pkg::CONT_B | {2'b0, cp[11:6]};
			seq[3] = utf8e_pkg::CONT_B | {2'b0, cp[5:0]};
		end else if (cp > utf8e_pkg::LIMIT_2B) begin
			len    = 3;
			seq[0] = utf8e_pkg::LEAD_3B | {4'b0, cp[15:12]};
			seq[1] = utf8e_pkg::CONT_B | {2'b0, cp[11:6]};
			seq[2] = utf8e_pkg::CONT_B | {2'b0, cp[5:0]};
		end else if (cp > utf8e_pkg::LIMIT_1B) begin
			len    = 2;
			seq[0] = utf8e_pkg::LEAD_2B | {3'b0, cp[10:6]};
			seq[1] = utf8e_pkg::CONT_B | {2'b0, cp[5:0]};
		end else begin
			len    = 1;
			seq[0] = cp[7:0];
		end
		if (rem_budget < len) begin
			halted = 1'b1;
			expect_byte(1'b0, 8'h00, 1'b1, utf8e_pkg::ST_NO_ROOM);
			return;
		end
		rem_budget = rem_budget - len[utf8e_pkg::BUDGET_W-1:0];
		// terminator spends budget but leaves the count alone
		if (cp == 0) begin
			halted = 1'b1;
			expect_byte(1'b1, 8'h00, 1'b1, utf8e_pkg::ST_TERM);
			return;
		end
		for (int i = 0; i < len; i++) begin
			enc_count = enc_count + 1'b1;
			expect_byte(1'b1, seq[i], i == len - 1, utf8e_pkg::ST_ENCODED);
		end
	endfunction

	// sender: bursts of transfers separated by random gaps
	always @(posedge clk) begin : drive_points
		point_t nxt;
		if (arst_n) begin
			if (in_valid && in_ready)
				encode_point(code_point, first_item);
			if (!in_valid || in_ready) begin
				if (gap_left != 0 || pending_points.size() == 0) begin
					in_valid <= 1'b0;
					if (gap_left != 0)
						gap_left--;
				end else begin
					nxt = pending_points.pop_front();
					code_point <= nxt.cp;
					first_item <= nxt.first;
					in_valid   <= 1'b1;
					if (burst_left <= 1) begin
						burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left--;
					end
				end
			end
		end
	end

	// receiver: stall behaviour switches randomly between four modes
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(20, 300);
		end else begin
			stall_left--;
		end
		stall_tick++;
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			2: out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= (stall_tick % 5 < 2);
		endcase
	end

	always @(posedge clk) begin : check_bytes
		enc_byte_t want;
		if (arst_n && out_valid && out_ready) begin
			if (due_bytes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transfer: v=%b b=%02h l=%b s=%0d n=%0d",
						byte_valid, out_byte, last, status, total_count);
			end else begin
				want = due_bytes.pop_front();
				if (byte_valid !== want.byte_valid || out_byte !== want.value ||
					last !== want.last || status !== want.status ||
					total_count !== want.total) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: expected v=%b b=%02h l=%b s=%0d n=%0d,",
							" got v=%b b=%02h l=%b s=%0d n=%0d"},
							want.byte_valid, want.value, want.last, want.status,
							want.total, byte_valid, out_byte, last, status,
							total_count);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == RUN_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic add_point(input logic [utf8e_pkg::CP_W-1:0] cp, input logic first);
		point_t p;
		p.cp    = cp;
		p.first = first;
		pending_points.push_back(p);
	endtask

	// wait until every queued point is taken and every byte has come out
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_points.size() != 0 || in_valid || due_bytes.size() != 0);
	endtask

	task automatic write_budget(input logic [utf8e_pkg::BUDGET_W-1:0] value);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we     <= 1'b0;
		budget_reg = value;
	endtask

	function automatic logic [utf8e_pkg::CP_W-1:0] random_point(input int unsigned kind);
		logic [utf8e_pkg::CP_W-1:0] v;
		case (kind)
			0: v = $urandom_range(1, utf8e_pkg::LIMIT_1B);
			1: v = $urandom_range(utf8e_pkg::LIMIT_1B + 1, utf8e_pkg::LIMIT_2B);
			2: v = $urandom_range(utf8e_pkg::LIMIT_2B + 1, utf8e_pkg::LIMIT_3B);
			3: v = $urandom_range(utf8e_pkg::LIMIT_3B + 1, utf8e_pkg::LIMIT_4B);
			default: begin
				v = $urandom;
				if (v <= utf8e_pkg::LIMIT_4B)
					v[31:21] = 11'($urandom_range(1, 11'h7ff));
			end
		endcase
		return v;
	endfunction

	// strings: a first item, random content, sometimes a terminator or an illegal value,
	// and a little noise after a string has ended
	task automatic queue_strings(input int unsigned n);
		int unsigned done;
		int unsigned str_len;
		int unsigned roll;
		done = 0;
		while (done < n) begin
			str_len = $urandom_range(1, 14);
			for (int i = 0; i < str_len && done < n; i++) begin
				roll = $urandom_range(0, 99);
				done++;
				if (roll < 5) begin
					add_point('0, i == 0);
					break;
				end else if (roll < 9) begin
					add_point(random_point(4), i == 0);
					break;
				end else begin
					add_point(random_point($urandom_range(0, 3)), i == 0);
				end
			end
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 2))
					add_point(random_point($urandom_range(0, 4)), 1'b0);
		end
	endtask

	initial begin
		logic [utf8e_pkg::BUDGET_W-1:0] budget;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reset budget is zero: never started, then nothing fits
		add_point(32'h0000_0041, 1'b0);
		add_point(32'h0000_0041, 1'b1);
		add_point(32'h0000_0042, 1'b0);
		add_point(32'hffff_ffff, 1'b1);

		write_budget(16'd200);
		add_point(32'h0000_007f, 1'b1);
		add_point(32'h0000_0080, 1'b0);
		add_point(32'h0000_07ff, 1'b0);
		add_point(32'h0000_0800, 1'b0);
		add_point(32'h0000_ffff, 1'b0);
		add_point(32'h0000_d800, 1'b0);
		add_point(32'h0001_0000, 1'b0);
		add_point(32'h001f_ffff, 1'b0);
		add_point(32'h0020_0000, 1'b0);
		add_point(32'h0000_0041, 1'b0);
		add_point(32'hffff_ffff, 1'b1);
		add_point(32'h0000_0001, 1'b1);
		add_point(32'h0000_0000, 1'b0);
		add_point(32'h0000_0041, 1'b0);

		write_budget(16'd3);
		add_point(32'h0001_0000, 1'b1);
		add_point(32'h0000_0800, 1'b1);
		add_point(32'h0000_0041, 1'b0);
		add_point(32'h8000_0000, 1'b1);

		write_budget(16'd1);
		add_point(32'h0000_0000, 1'b1);
		add_point(32'h0000_0041, 1'b1);
		add_point(32'h0000_0000, 1'b0);

		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
				0: budget = 16'd1;
				1: budget = 16'hffff;
				2: budget = 16'd2;
				3: budget = 16'd0;
				4: budget = 16'd4;
				5: budget = 16'hffff;
				6: budget = utf8e_pkg::BUDGET_W'($urandom_range(3, 12));
				default: budget = utf8e_pkg::BUDGET_W'($urandom_range(13, 80));
			endcase
			write_budget(budget);
			queue_strings(32);
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
